FILE: sv/vpa_pkg.sv
// Shared constants, types and the arctangent table for the vector pair angle block.
`default_nettype none

package vpa_pkg;

  localparam int CompW          = 16;
  localparam int ProdW          = 2 * CompW;
  localparam int SumW           = ProdW + 1;
  localparam int MagW           = 2 * CompW;
  localparam int NormSteps      = $clog2(MagW);
  localparam int NormTop        = 60;
  localparam int Place          = NormTop + 1 - MagW;
  localparam int DpW            = 64;
  localparam int AccW           = 32;
  localparam int AngW           = 16;
  localparam int RotationStages = 18;
  localparam int CordicStages   = (RotationStages > 32) ? 32 : RotationStages;
  localparam int QueueDepth     = 4;
  localparam int QueuePtrW      = $clog2(QueueDepth);
  localparam int QueueCntW      = QueuePtrW + 1;

  localparam logic [AccW-1:0] AccHalf  = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [AccW-1:0] AccRound = AccW'(1) << (AccW - AngW - 1);

  // atan(2^-i) in binary angle units, 2^32 = one full turn
  localparam logic [AccW-1:0] AtanTurns [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  // classified pair: direction kind, zero flag, half turn start, sign of rotated y, magnitudes of cross and dot
  typedef struct packed {
    logic            kind;
    logic            zero;
    logic            half;
    logic            ny;
    logic [MagW-1:0] mc;
    logic [MagW-1:0] md;
  } vpa_item_t;

  typedef struct packed {
    logic                   kind;
    logic                   zero;
    logic signed [DpW-1:0]  x;
    logic signed [DpW-1:0]  y;
    logic        [AccW-1:0] z;
  } vpa_rot_t;

endpackage

`default_nettype wire

FILE: sv/vector_pair_angle.sv
// Angle from a first to a second 2-D vector (top level): cross/dot front end, queue, CORDIC back end.
// The block takes one vector pair per clock unless stalled and returns the counter-clockwise
// (tuser 0) or clockwise (tuser 1) angle from a to b as a 16-bit binary angle, 65536 = one turn,
// rounded and wrapped; a pair where either vector is zero gives 0. With no back pressure, a
// transaction passes through one product register, the queue write and registered read, five
// normalizer steps, eighteen CORDIC stages and the output register. The four-entry queue lets
// the front end keep taking transactions while the output is stalled, until it is full;
// throughput is one transaction per cycle while the output is not stalled.
`default_nettype none

module vector_pair_angle (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  wire  [63:0]  s_axis_tdata_i,   // a_x[15:0], a_y[31:16], b_x[47:32], b_y[63:48]
  input  wire  [0:0]   s_axis_tuser_i,   // kind[0]
  output logic         m_axis_tvalid_o,
  input  wire          m_axis_tready_i,
  output logic [15:0]  m_axis_tdata_o    // angle[15:0]
);
  import vpa_pkg::*;

  logic                    push, pop, full, empty;
  vpa_item_t               push_item, pop_item;
  logic signed [CompW-1:0] a_x, a_y, b_x, b_y;

  assign a_x = s_axis_tdata_i[CompW-1:0];
  assign a_y = s_axis_tdata_i[2*CompW-1:CompW];
  assign b_x = s_axis_tdata_i[3*CompW-1:2*CompW];
  assign b_y = s_axis_tdata_i[4*CompW-1:3*CompW];

  vpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .kind_i     (s_axis_tuser_i[0]),
    .a_x_i      (a_x),
    .a_y_i      (a_y),
    .b_x_i      (b_x),
    .b_y_i      (b_y),
    .push_o     (push),
    .item_o     (push_item),
    .full_i     (full)
  );

  vpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_item),
    .empty_o (empty)
  );

  vpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .item_i      (pop_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .angle_o     (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

FILE: sv/vpa_front.sv
// Front end: accepts vector pairs, forms cross and dot products, classifies them.
`default_nettype none

module vpa_front (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 kind_i,
  input  wire  signed [vpa_pkg::CompW-1:0]    a_x_i,
  input  wire  signed [vpa_pkg::CompW-1:0]    a_y_i,
  input  wire  signed [vpa_pkg::CompW-1:0]    b_x_i,
  input  wire  signed [vpa_pkg::CompW-1:0]    b_y_i,
  output logic                                push_o,
  output vpa_pkg::vpa_item_t                  item_o,
  input  wire                                 full_i
);
  import vpa_pkg::*;

  logic                    valid_q, valid_d;
  logic                    kind_q;
  logic signed [ProdW-1:0] axbx_q, ayby_q, axby_q, aybx_q;
  logic signed [ProdW-1:0] axbx_d, ayby_d, axby_d, aybx_d;
  logic signed [SumW-1:0]  cross_sum, dot;
  logic        [SumW-1:0]  cross_mag, dot_mag;
  logic                    accept;

  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;

  assign axbx_d = a_x_i * b_x_i;
  assign ayby_d = a_y_i * b_y_i;
  assign axby_d = a_x_i * b_y_i;
  assign aybx_d = a_y_i * b_x_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      axbx_q <= axbx_d;
      ayby_q <= ayby_d;
      axby_q <= axby_d;
      aybx_q <= aybx_d;
    end
  end

  always_comb begin
    cross_sum = SumW'(axby_q) - SumW'(aybx_q);
    dot       = SumW'(axbx_q) + SumW'(ayby_q);
    cross_mag = cross_sum[SumW-1] ? -cross_sum : cross_sum;
    dot_mag   = dot[SumW-1] ? -dot : dot;
    item_o.kind = kind_q;
    item_o.zero = (cross_sum == '0) && (dot == '0);
    item_o.half = dot[SumW-1];
    item_o.ny   = cross_sum[SumW-1] ^ dot[SumW-1];
    item_o.mc   = cross_mag[MagW-1:0];
    item_o.md   = dot_mag[MagW-1:0];
  end

endmodule

`default_nettype wire

FILE: sv/vpa_queue.sv
// Short queue between front and back end, registered read port.
`default_nettype none

module vpa_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  vpa_pkg::vpa_item_t  wdata_i,
  output logic                full_o,
  input  wire                 pop_i,
  output vpa_pkg::vpa_item_t  rdata_o,
  output logic                empty_o
);
  import vpa_pkg::*;

  vpa_item_t             mem [QueueDepth];
  vpa_item_t             rdata_q;
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign rdata_o = rdata_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

FILE: sv/vpa_back.sv
// Back end: normalizer, unrolled CORDIC vectoring pipeline and output register.
`default_nettype none

module vpa_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          empty_i,
  output logic                         pop_o,
  input  vpa_pkg::vpa_item_t           item_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [vpa_pkg::AngW-1:0]     angle_o
);
  import vpa_pkg::*;

  logic                      en;
  logic                      v0_q;
  vpa_item_t                 n_q  [NormSteps];
  logic [NormSteps-1:0]      nv_q;
  vpa_rot_t                  r_q  [CordicStages];
  logic [CordicStages-1:0]   rv_q;
  vpa_rot_t                  rot0;
  logic [DpW-1:0]            xm, ym;
  logic [MagW-1:0]           norm_or;
  logic [AccW-1:0]           z_dir, z_rnd;
  logic                      out_valid_q;
  logic [AngW-1:0]           angle_q, angle_d;

  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = out_valid_q;
  assign angle_o     = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= !empty_i;
    end
  end

  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int Sh = 1 << (NormSteps - 1 - k);
    vpa_item_t       src, nxt;
    logic            src_v;
    logic [MagW-1:0] both;

    if (k == 0) begin : g_first
      assign src   = item_i;
      assign src_v = v0_q;
    end else begin : g_rest
      assign src   = n_q[k-1];
      assign src_v = nv_q[k-1];
    end

    always_comb begin
      nxt  = src;
      both = src.mc | src.md;
      if (both[MagW-1 -: Sh] == '0) begin
        nxt.mc = src.mc << Sh;
        nxt.md = src.md << Sh;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k] <= 1'b0;
      end else if (en) begin
        nv_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        n_q[k] <= nxt;
      end
    end
  end

  assign norm_or = n_q[NormSteps-1].mc | n_q[NormSteps-1].md;

  always_comb begin
    xm        = DpW'(n_q[NormSteps-1].md) << Place;
    ym        = DpW'(n_q[NormSteps-1].mc) << Place;
    rot0.kind = n_q[NormSteps-1].kind;
    rot0.zero = n_q[NormSteps-1].zero;
    rot0.x    = xm;
    rot0.y    = n_q[NormSteps-1].ny ? -ym : ym;
    rot0.z    = n_q[NormSteps-1].half ? AccHalf : '0;
  end

  for (genvar i = 0; i < CordicStages; i++) begin : g_rot
    vpa_rot_t              src, nxt;
    logic                  src_v;
    logic signed [DpW-1:0] sx, sy, dx, dy;

    if (i == 0) begin : g_first
      assign src   = rot0;
      assign src_v = nv_q[NormSteps-1];
    end else begin : g_rest
      assign src   = r_q[i-1];
      assign src_v = rv_q[i-1];
    end

    always_comb begin
      sx  = src.x;
      sy  = src.y;
      dx  = sy >>> i;
      dy  = sx >>> i;
      nxt = src;
      if (sy[DpW-1]) begin
        nxt.x = sx - dx;
        nxt.y = sy + dy;
        nxt.z = src.z - AtanTurns[i];
      end else begin
        nxt.x = sx + dx;
        nxt.y = sy - dy;
        nxt.z = src.z + AtanTurns[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else if (en) begin
        rv_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[i] <= nxt;
      end
    end
  end

  always_comb begin
    z_dir   = r_q[CordicStages-1].kind ? -r_q[CordicStages-1].z : r_q[CordicStages-1].z;
    z_rnd   = z_dir + AccRound;
    angle_d = r_q[CordicStages-1].zero ? '0 : z_rnd[AccW-1 -: AngW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= rv_q[CordicStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      angle_q <= angle_d;
    end
  end

  a_norm_msb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nv_q[NormSteps-1] && !n_q[NormSteps-1].zero) |-> norm_or[MagW-1])
    else $error("normalizer left a nonzero pair unnormalized");

  a_x_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rv_q[CordicStages-1] && !r_q[CordicStages-1].zero) |-> !r_q[CordicStages-1].x[DpW-1])
    else $error("rotated x went negative");

  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && rv_q[CordicStages-1] && r_q[CordicStages-1].zero) |=> (angle_q == '0))
    else $error("zero pair did not give a zero angle");

endmodule

`default_nettype wire
